@@ sv/overwrite_ring_buffer_assert.svh @@
// Assertion macros for the overwriting ring buffer.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef OVERWRITE_RING_BUFFER_ASSERT_SVH
`define OVERWRITE_RING_BUFFER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset
`define ORB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked outside reset
`define ORB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ORB_ASSERT_IMPL(lbl, ante, cons, msg)
`define ORB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ sv/orb_pkg.sv @@
// Shared types, codes and constants for the overwriting ring buffer.
// No dependencies; used by every module of the block except the sample store.
package orb_pkg;

  localparam int RING_DEPTH_DEF  = 4096;
  localparam int SAMPLE_BITS_DEF = 64;
  localparam int MAX_BURST_DEF   = 64;
  localparam int LOG2_LIMIT      = 12;
  localparam logic [3:0] CFG_LOG2_RESET = 4'd12;

  // Request codes
  localparam logic REQ_PUSH    = 1'b0;
  localparam logic REQ_CONSUME = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_ADJ  = 4'b0100,
    ST_EMIT = 4'b1000
  } orb_state_t;

  typedef struct packed {
    logic        req_type;
    logic [63:0] sample_in;
    logic [63:0] reader_seq;
    logic [6:0]  max_count;
  } orb_in_t;

  typedef struct packed {
    logic [63:0] sample_out;
    logic [63:0] sample_seq;
    logic        has_sample;
    logic        last;
    logic [63:0] new_reader_seq;
    logic [63:0] skipped;
    logic [63:0] dropped_total;
    logic        more_available;
  } orb_out_t;

  // One result issued by the sequencer; sample data follows from memory
  typedef struct packed {
    logic        valid;
    logic        has_sample;
    logic        last;
    logic        more_available;
    logic [63:0] sample_seq;
    logic [63:0] new_reader_seq;
    logic [63:0] skipped;
    logic [63:0] dropped_total;
  } orb_issue_t;

  // Largest k with 2^k <= v (elaboration only)
  function automatic int floor_log2(input int unsigned v);
    int r;
    r = 0;
    for (int i = 0; i < 32; i++) begin
      if ((64'd1 << i) <= 64'(v)) r = i;
    end
    return r;
  endfunction

endpackage

@@ sv/orb_mem.sv @@
// Sample store: one write port, one read port, registered read data.
// Depends on nothing; read data holds when no read is enabled.
module orb_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data stays put until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/orb_ctrl.sv @@
// Sequencer: head and dropped counters, overrun catch-up and result issue.
// Depends on orb_pkg; drives the sample store ports.
module orb_ctrl #(
  parameter int RING_DEPTH  = orb_pkg::RING_DEPTH_DEF,
  parameter int SAMPLE_BITS = orb_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_BURST   = orb_pkg::MAX_BURST_DEF,
  parameter int LG_MAX      = 12,
  parameter int SZW         = 13,
  parameter int AW          = 12,
  parameter int CW          = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  orb_pkg::orb_in_t       in_data,
  input  logic [3:0]             ring_log2,
  input  logic                   issue_ok,
  output orb_pkg::orb_issue_t    iss,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_waddr,
  output logic [SAMPLE_BITS-1:0] mem_wdata,
  output logic                   mem_re,
  output logic [AW-1:0]          mem_raddr
);

  localparam int NW = (SZW > CW) ? SZW : CW;

  orb_pkg::orb_state_t state_r, state_nxt;
  logic [63:0]    head_r, head_nxt;
  logic [63:0]    dropped_r, dropped_nxt;
  logic [63:0]    seq_r, seq_nxt;
  logic [63:0]    diff_r, diff_nxt;
  logic           gt_r, gt_nxt;
  logic [CW-1:0]  maxc_r, maxc_nxt;
  logic [63:0]    skip_r, skip_nxt;
  logic [SZW-1:0] avail_r, avail_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  logic [3:0]     lg_sat, lg_eff;
  logic [SZW-1:0] size;
  logic [AW-1:0]  mask;
  logic           over;
  logic           diff_hi;

  // Ring size from the register, clamped to the limit and the memory depth
  always_comb begin
    lg_sat = (ring_log2 > 4'(orb_pkg::LOG2_LIMIT)) ? 4'(orb_pkg::LOG2_LIMIT) : ring_log2;
    lg_eff = (lg_sat > 4'(LG_MAX)) ? 4'(LG_MAX) : lg_sat;
    size   = SZW'(1) << lg_eff;
    mask   = AW'(size - SZW'(1));
  end

  // Reader lags by more than one ring: diff > size
  always_comb begin
    if (SZW < 64) begin
      diff_hi = (diff_r >> SZW) != 64'd0;
    end else begin
      diff_hi = 1'b0;
    end
    over = gt_r && (diff_hi || (diff_r[SZW-1:0] > size));
  end

  assign in_ready  = (state_r == orb_pkg::ST_IDLE);
  assign mem_waddr = head_r[AW-1:0] & mask;
  assign mem_wdata = in_data.sample_in[SAMPLE_BITS-1:0];
  assign mem_raddr = seq_r[AW-1:0] & mask;
  assign mem_re    = iss.valid && iss.has_sample;

  // Sequencer next state
  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    dropped_nxt = dropped_r;
    seq_nxt     = seq_r;
    diff_nxt    = diff_r;
    gt_nxt      = gt_r;
    maxc_nxt    = maxc_r;
    skip_nxt    = skip_r;
    avail_nxt   = avail_r;
    cnt_nxt     = cnt_r;
    mem_we      = 1'b0;
    iss         = '0;

    unique case (state_r)
      orb_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_data.req_type == orb_pkg::REQ_PUSH) begin
            mem_we   = 1'b1;
            head_nxt = head_r + 64'd1;
          end else begin
            seq_nxt  = in_data.reader_seq;
            gt_nxt   = head_r > in_data.reader_seq;
            diff_nxt = head_r - in_data.reader_seq;
            maxc_nxt = (in_data.max_count > 7'(MAX_BURST)) ? CW'(MAX_BURST)
                                                           : CW'(in_data.max_count);
            state_nxt = orb_pkg::ST_CALC;
          end
        end
      end
      orb_pkg::ST_CALC: begin
        // catch up to the oldest live sample; seq + skip equals head - size
        skip_nxt = over ? (diff_r - 64'(size)) : 64'd0;
        if (over) begin
          seq_nxt = head_r - 64'(size);
        end
        avail_nxt = !gt_r ? '0 : (over ? size : diff_r[SZW-1:0]);
        state_nxt = orb_pkg::ST_ADJ;
      end
      orb_pkg::ST_ADJ: begin
        dropped_nxt = dropped_r + skip_r;
        cnt_nxt     = (NW'(avail_r) < NW'(maxc_r)) ? CW'(avail_r) : maxc_r;
        state_nxt   = orb_pkg::ST_EMIT;
      end
      orb_pkg::ST_EMIT: begin
        if (issue_ok) begin
          iss.valid         = 1'b1;
          iss.skipped       = skip_r;
          iss.dropped_total = dropped_r;
          if (cnt_r == '0) begin
            // empty read or zero count: one result without a sample
            iss.has_sample     = 1'b0;
            iss.last           = 1'b1;
            iss.sample_seq     = 64'd0;
            iss.new_reader_seq = seq_r;
            iss.more_available = avail_r != '0;
            state_nxt          = orb_pkg::ST_IDLE;
          end else begin
            iss.has_sample     = 1'b1;
            iss.last           = cnt_r == CW'(1);
            iss.sample_seq     = seq_r;
            iss.new_reader_seq = seq_r + 64'd1;
            iss.more_available = avail_r != SZW'(1);
            seq_nxt            = seq_r + 64'd1;
            avail_nxt          = avail_r - SZW'(1);
            cnt_nxt            = cnt_r - CW'(1);
            if (cnt_r == CW'(1)) begin
              state_nxt = orb_pkg::ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = orb_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= orb_pkg::ST_IDLE;
      head_r    <= 64'd0;
      dropped_r <= 64'd0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // Working registers of one consume
  always_ff @(posedge clk) begin
    seq_r   <= seq_nxt;
    diff_r  <= diff_nxt;
    gt_r    <= gt_nxt;
    maxc_r  <= maxc_nxt;
    skip_r  <= skip_nxt;
    avail_r <= avail_nxt;
    cnt_r   <= cnt_nxt;
  end

endmodule

@@ sv/orb_out.sv @@
// Result stage: pairs memory read data with issued result info, output register.
// Depends on orb_pkg; two entries deep, so one result per cycle under flow.
module orb_out #(
  parameter int SAMPLE_BITS = orb_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  orb_pkg::orb_issue_t    iss,
  input  logic [SAMPLE_BITS-1:0] rdata,
  output logic                   issue_ok,
  output logic                   out_valid,
  input  logic                   out_ready,
  output orb_pkg::orb_out_t      out_data
);

  orb_pkg::orb_issue_t meta_r;
  logic                mvalid_r;
  logic                out_valid_r;
  orb_pkg::orb_out_t   out_data_r;
  logic                load;

  // memory stage moves to the output register when that one frees up
  assign load     = mvalid_r && (!out_valid_r || out_ready);
  assign issue_ok = !mvalid_r || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (iss.valid) begin
        mvalid_r <= 1'b1;
      end else if (load) begin
        mvalid_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (iss.valid) begin
      meta_r <= iss;
    end
    if (load) begin
      out_data_r.sample_out     <= meta_r.has_sample ? 64'(rdata) : 64'd0;
      out_data_r.sample_seq     <= meta_r.sample_seq;
      out_data_r.has_sample     <= meta_r.has_sample;
      out_data_r.last           <= meta_r.last;
      out_data_r.new_reader_seq <= meta_r.new_reader_seq;
      out_data_r.skipped        <= meta_r.skipped;
      out_data_r.dropped_total  <= meta_r.dropped_total;
      out_data_r.more_available <= meta_r.more_available;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sv/overwrite_ring_buffer.sv @@
// Overwriting ring buffer. A push writes the sample store from idle. A consume
// passes the calc and adjust states, then issues 1 to MAX_BURST results, one per
// cycle while the result stage accepts them, each reading the sample store (its
// single read port) unless it has no sample. The next item is taken once the last
// result of a consume is issued. Reset clears head and dropped counts and sets the
// size register to 12; the sample store is not cleared.
`include "overwrite_ring_buffer_assert.svh"
module overwrite_ring_buffer #(
  parameter int RING_DEPTH  = orb_pkg::RING_DEPTH_DEF,
  parameter int SAMPLE_BITS = orb_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_BURST   = orb_pkg::MAX_BURST_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  orb_pkg::orb_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output orb_pkg::orb_out_t out_data,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata
);

  localparam int LG_MAX = orb_pkg::floor_log2(RING_DEPTH);
  localparam int SZW    = LG_MAX + 1;
  localparam int AW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW     = $clog2(MAX_BURST + 1);

  logic [3:0]             cfg_r;
  logic                   issue_ok;
  orb_pkg::orb_issue_t    iss;
  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [SAMPLE_BITS-1:0] mem_wdata, mem_rdata;

  // Ring size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= orb_pkg::CFG_LOG2_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  orb_ctrl #(
    .RING_DEPTH (RING_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_BURST  (MAX_BURST),
    .LG_MAX     (LG_MAX),
    .SZW        (SZW),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .ring_log2(cfg_r),
    .issue_ok (issue_ok),
    .iss      (iss),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr)
  );

  // Writes come only from pushes in idle; reads come only from results issued in the
  // emit state, so no write/read overlap on one entry.
  orb_mem #(
    .DEPTH(RING_DEPTH),
    .AW   (AW),
    .DW   (SAMPLE_BITS)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  orb_out #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .iss      (iss),
    .rdata    (mem_rdata),
    .issue_ok (issue_ok),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Checks
  `ORB_ASSERT_IMPL(a_empty_is_last, out_valid && !out_data.has_sample, out_data.last, "empty result without last")
  `ORB_ASSERT_IMPL(a_seq_advance, out_valid && out_data.has_sample, out_data.new_reader_seq == out_data.sample_seq + 64'd1, "reader seq not advanced by one")
  `ORB_ASSERT_IMPL(a_more_mid_burst, out_valid && out_data.has_sample && !out_data.last, out_data.more_available, "burst continues without more samples")
  `ORB_ASSERT_NEXT(a_push_one_cycle, in_valid && in_ready && (in_data.req_type == orb_pkg::REQ_PUSH), in_ready, "push did not complete in one cycle")

endmodule
